// ----- hdl/random_permutation_shuffle_unit_macros.svh -----
// Assertion macros for the random permutation shuffle unit.
`ifndef RANDOM_PERMUTATION_SHUFFLE_UNIT_MACROS_SVH
`define RANDOM_PERMUTATION_SHUFFLE_UNIT_MACROS_SVH

`ifndef SYNTH
`define RPS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rps assertion failed");
`define RPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rps assertion failed");
`else
`define RPS_ASSERT_SAME(label, clk, rst, ante, cons)
`define RPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/rps_pkg.sv -----
// Types and constants of the random permutation shuffle unit.
package rps_pkg;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SWAP
  } state_t;

  localparam int unsigned LEN_RESET = 16;

endpackage

// ----- hdl/random_permutation_shuffle_unit.sv -----
// Top level of the random permutation shuffle unit: Fisher-Yates over a dual-port store.
//
//   channel   dir  handshake              payload
//   s_*       in   s_tvalid / s_tready    s_tdata: random_word
//   m_*       out  m_tvalid / m_tready    m_tdata: position, element; m_tlast: last
//   length_*  in   length_wr_en           length_wr_data: perm_length
//
// No new word is taken until the last one is through: the dual-port store reads entries
// i and j in the accept cycle and writes both back in S_SWAP once the output can take it.
// After rst or a length write the store tag sweep clears every entry, s_tready low.
// A result waits in the output register; the swap holds while it is not taken.
`include "random_permutation_shuffle_unit_macros.svh"

module random_permutation_shuffle_unit #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned RANDOM_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // random_word
  input  logic [((RANDOM_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // position, element
  output logic [(($clog2(MAX_ELEMENTS) + $clog2(MAX_ELEMENTS + 1) + 7) / 8) * 8 - 1:0]
                                                m_tdata,
  output logic                                  m_tlast,
  input  logic                                  length_wr_en,
  input  logic [$clog2(MAX_ELEMENTS + 1) - 1:0] length_wr_data
);

  localparam int unsigned POS_W  = $clog2(MAX_ELEMENTS);
  localparam int unsigned EL_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned OUT_TW = ((POS_W + EL_W + 7) / 8) * 8;
  localparam int unsigned PROD_W = EL_W + RANDOM_BITS;
  localparam int unsigned RST_LEN =
    (rps_pkg::LEN_RESET > MAX_ELEMENTS) ? MAX_ELEMENTS : rps_pkg::LEN_RESET;

  rps_pkg::state_t state;
  rps_pkg::state_t state_next;

  logic [EL_W-1:0]   eff_len;
  logic [EL_W-1:0]   len_clamped;
  logic [POS_W-1:0]  step_index;
  logic              epoch;
  logic [POS_W-1:0]  clr_addr;
  logic [POS_W-1:0]  i_reg;
  logic [POS_W-1:0]  j_reg;
  logic [EL_W:0]     rd_a;
  logic [EL_W:0]     rd_b;
  logic [EL_W:0]     mem [MAX_ELEMENTS];

  logic [RANDOM_BITS-1:0] rnd;
  logic [EL_W-1:0]   span;
  logic [PROD_W-1:0] prod;
  logic [EL_W:0]     j_sum;
  logic [POS_W-1:0]  j_calc;
  logic [EL_W-1:0]   val_a;
  logic [EL_W-1:0]   val_b;
  logic              is_last;
  logic              accept;
  logic              out_load;
  logic              clr_we;
  logic              swap_we;
  logic              clr_done;

  logic [POS_W-1:0]  out_pos;
  logic [EL_W-1:0]   out_elem;

  // partner index
  always_comb begin
    rnd   = s_tdata[RANDOM_BITS-1:0];
    span  = eff_len - EL_W'(step_index);
    prod  = PROD_W'(span) * PROD_W'(rnd);
    j_sum = (EL_W + 1)'(step_index) + (EL_W + 1)'(prod >> RANDOM_BITS);
    if (j_sum > (EL_W + 1)'(eff_len - 1'b1)) begin
      j_calc = POS_W'(eff_len - 1'b1);
    end else begin
      j_calc = j_sum[POS_W-1:0];
    end
  end

  always_comb begin
    if (length_wr_data == '0) begin
      len_clamped = EL_W'(1);
    end else if (length_wr_data > EL_W'(MAX_ELEMENTS)) begin
      len_clamped = EL_W'(MAX_ELEMENTS);
    end else begin
      len_clamped = length_wr_data;
    end
  end

  always_comb begin
    val_a   = (rd_a[EL_W] == epoch) ? rd_a[EL_W-1:0] : EL_W'(i_reg) + 1'b1;
    val_b   = (rd_b[EL_W] == epoch) ? rd_b[EL_W-1:0] : EL_W'(j_reg) + 1'b1;
    is_last = (EL_W'(i_reg) == eff_len - 1'b1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rps_pkg::S_CLEAR: begin
        if (clr_done) state_next = rps_pkg::S_IDLE;
      end
      rps_pkg::S_IDLE: begin
        if (accept) state_next = rps_pkg::S_SWAP;
      end
      rps_pkg::S_SWAP: begin
        if (out_load) state_next = rps_pkg::S_IDLE;
      end
      default: state_next = rps_pkg::S_CLEAR;
    endcase
    if (length_wr_en) state_next = rps_pkg::S_CLEAR;
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    clr_we   = 1'b0;
    out_load = 1'b0;
    case (state)
      rps_pkg::S_CLEAR: clr_we = 1'b1;
      rps_pkg::S_IDLE:  s_tready = 1'b1;
      rps_pkg::S_SWAP:  out_load = !m_tvalid || m_tready;
      default: ;
    endcase
    accept   = s_tvalid && s_tready && !length_wr_en;
    swap_we  = out_load && !length_wr_en;
    clr_done = (clr_addr == POS_W'(MAX_ELEMENTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rps_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len    <= EL_W'(RST_LEN);
      step_index <= '0;
      epoch      <= 1'b1;
      clr_addr   <= '0;
    end else if (length_wr_en) begin
      eff_len    <= len_clamped;
      step_index <= '0;
      epoch      <= 1'b1;
      clr_addr   <= '0;
    end else begin
      if (clr_we && !clr_done) clr_addr <= clr_addr + 1'b1;
      if (swap_we) begin
        step_index <= is_last ? '0 : i_reg + 1'b1;
        if (is_last) epoch <= !epoch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_reg <= step_index;
      j_reg <= j_calc;
    end
  end

  // dual-port store: read both entries on accept, write both back on swap
  always_ff @(posedge clk) begin
    if (clr_we) begin
      mem[clr_addr] <= '0;
    end else if (swap_we) begin
      mem[i_reg] <= {epoch, val_b};
    end
    if (swap_we && j_reg != i_reg) begin
      mem[j_reg] <= {epoch, val_a};
    end
    if (accept) begin
      rd_a <= mem[step_index];
      rd_b <= mem[j_calc];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos  <= i_reg;
      out_elem <= val_b;
      m_tlast  <= is_last;
    end
  end

  assign m_tdata = OUT_TW'({out_elem, out_pos});

  `RPS_ASSERT_SAME(a_step_range, clk, rst, 1'b1, EL_W'(step_index) < eff_len)
  `RPS_ASSERT_NEXT(a_accept_swap, clk, rst, accept, state == rps_pkg::S_SWAP)
  `RPS_ASSERT_SAME(a_clear_epoch, clk, rst, state == rps_pkg::S_CLEAR, epoch)
  `RPS_ASSERT_NEXT(a_swap_out, clk, rst, out_load, m_tvalid)

endmodule
